@@ rtl/itrd_pkg.sv @@
package itrd_pkg;

  localparam int VALUE_W   = 32;
  localparam int RADIX_W   = 5;
  localparam int SYMBOL_W  = 8;
  localparam int LENGTH_W  = 6;
  localparam int DIGIT_W   = 4;
  localparam int MAX_DIGITS = 32;
  localparam int DIG_IDX_W = $clog2(MAX_DIGITS);
  // Dividend bits consumed per cycle by the shared divide step.
  localparam int CHUNK_W   = 8;
  localparam int CHUNKS    = VALUE_W / CHUNK_W;
  localparam int STEP_W    = $clog2(CHUNKS);

  localparam logic [RADIX_W-1:0]  RADIX_MIN = RADIX_W'(2);
  localparam logic [RADIX_W-1:0]  RADIX_MAX = RADIX_W'(16);
  localparam logic [SYMBOL_W-1:0] SIGN_CODE = SYMBOL_W'(45);
  localparam logic [SYMBOL_W-1:0] TERM_CODE = SYMBOL_W'(0);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_DIGIT,
    ST_TERM
  } state_t;

endpackage

@@ rtl/itrd_in_if.sv @@
interface itrd_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [itrd_pkg::VALUE_W-1:0] value;
  logic        [itrd_pkg::RADIX_W-1:0] radix;

  modport source (output valid, output value, output radix, input ready);
  modport sink   (input valid, input value, input radix, output ready);
endinterface

@@ rtl/itrd_out_if.sv @@
interface itrd_out_if;
  logic                           valid;
  logic                           ready;
  logic [itrd_pkg::SYMBOL_W-1:0]  symbol;
  logic                           last;
  logic [itrd_pkg::LENGTH_W-1:0]  length;

  modport source (output valid, output symbol, output last, output length, input ready);
  modport sink   (input valid, input symbol, input last, input length, output ready);
endinterface

@@ rtl/integer_to_radix_digits_core.sv @@
// Each digit is produced by stepping the shared divide unit through the dividend chunks
// (8 quotient bits per cycle); a conversion yields D digits (1 to 32), after which the
// first symbol is registered from the sign or digit state. A conversion emits S symbols
// (2 to 34), the most for base 2 and the most negative value.
// The input is ready only while no conversion is in progress.
// Reset (rst_n low, synchronous) returns the sequencer to idle and drops out valid.
module integer_to_radix_digits_core (
  input  logic       clk,
  input  logic       rst_n,
  itrd_in_if.sink    in_ch,
  itrd_out_if.source out_ch
);

  itrd_pkg::state_t state_r, state_nxt;

  logic [itrd_pkg::VALUE_W-1:0]   work_r, work_nxt;
  logic [itrd_pkg::DIGIT_W-1:0]   rem_r, rem_nxt;
  logic [itrd_pkg::RADIX_W-1:0]   radix_r, radix_nxt;
  logic                           neg_r, neg_nxt;
  logic [itrd_pkg::STEP_W-1:0]    step_r, step_nxt;
  logic [itrd_pkg::LENGTH_W-1:0]  ndig_r, ndig_nxt;
  logic [itrd_pkg::DIG_IDX_W-1:0] idx_r, idx_nxt;

  logic                           out_valid_r, out_valid_nxt;
  logic [itrd_pkg::SYMBOL_W-1:0]  symbol_r, symbol_nxt;
  logic                           last_r, last_nxt;
  logic [itrd_pkg::LENGTH_W-1:0]  length_r, length_nxt;

  logic [itrd_pkg::DIGIT_W-1:0]   dig_mem [itrd_pkg::MAX_DIGITS];
  logic                           dig_we;
  logic [itrd_pkg::DIGIT_W-1:0]   dig_rd_r;

  logic [itrd_pkg::RADIX_W-1:0]   part;
  logic [itrd_pkg::CHUNK_W-1:0]   qbits;
  logic [itrd_pkg::VALUE_W-1:0]   quo_next;
  logic                           emit_ok;

  assign in_ch.ready   = (state_r == itrd_pkg::ST_IDLE);
  assign out_ch.valid  = out_valid_r;
  assign out_ch.symbol = symbol_r;
  assign out_ch.last   = last_r;
  assign out_ch.length = length_r;

  // Shared divide step: restoring division of the top chunk of the dividend by the
  // base, with the running remainder carried between chunks.
  always_comb begin
    part  = {1'b0, rem_r};
    qbits = '0;
    for (int i = 0; i < itrd_pkg::CHUNK_W; i++) begin
      part = {part[itrd_pkg::RADIX_W-2:0], work_r[itrd_pkg::VALUE_W-1-i]};
      if (part >= radix_r) begin
        part = part - radix_r;
        qbits[itrd_pkg::CHUNK_W-1-i] = 1'b1;
      end
    end
    quo_next = {work_r[itrd_pkg::VALUE_W-itrd_pkg::CHUNK_W-1:0], qbits};
  end

  assign emit_ok = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt     = state_r;
    work_nxt      = work_r;
    rem_nxt       = rem_r;
    radix_nxt     = radix_r;
    neg_nxt       = neg_r;
    step_nxt      = step_r;
    ndig_nxt      = ndig_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    symbol_nxt    = symbol_r;
    last_nxt      = last_r;
    length_nxt    = length_r;
    dig_we        = 1'b0;

    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      itrd_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          neg_nxt  = in_ch.value[itrd_pkg::VALUE_W-1];
          // The most negative value negates to itself, which is 2^31 as unsigned.
          work_nxt = in_ch.value[itrd_pkg::VALUE_W-1] ? (~in_ch.value + 1'b1) : in_ch.value;
          priority if (in_ch.radix < itrd_pkg::RADIX_MIN) begin
            radix_nxt = itrd_pkg::RADIX_MIN;
          end else if (in_ch.radix > itrd_pkg::RADIX_MAX) begin
            radix_nxt = itrd_pkg::RADIX_MAX;
          end else begin
            radix_nxt = in_ch.radix;
          end
          rem_nxt   = '0;
          step_nxt  = '0;
          ndig_nxt  = '0;
          state_nxt = itrd_pkg::ST_DIV;
        end
      end
      itrd_pkg::ST_DIV: begin
        work_nxt = quo_next;
        rem_nxt  = part[itrd_pkg::DIGIT_W-1:0];
        step_nxt = step_r + 1'b1;
        if (step_r == itrd_pkg::STEP_W'(itrd_pkg::CHUNKS - 1)) begin
          // Remainder is the next digit, least significant first. A zero value
          // still yields one digit because the quotient is tested only here.
          dig_we   = 1'b1;
          ndig_nxt = ndig_r + 1'b1;
          rem_nxt  = '0;
          if (quo_next == '0) begin
            idx_nxt   = ndig_r[itrd_pkg::DIG_IDX_W-1:0];
            state_nxt = neg_r ? itrd_pkg::ST_SIGN : itrd_pkg::ST_DIGIT;
          end
        end
      end
      itrd_pkg::ST_SIGN: begin
        if (emit_ok) begin
          out_valid_nxt = 1'b1;
          symbol_nxt    = itrd_pkg::SIGN_CODE;
          last_nxt      = 1'b0;
          length_nxt    = '0;
          state_nxt     = itrd_pkg::ST_DIGIT;
        end
      end
      itrd_pkg::ST_DIGIT: begin
        if (emit_ok) begin
          out_valid_nxt = 1'b1;
          symbol_nxt    = {{(itrd_pkg::SYMBOL_W-itrd_pkg::DIGIT_W){1'b0}}, dig_rd_r};
          last_nxt      = 1'b0;
          length_nxt    = '0;
          if (idx_r == '0) begin
            state_nxt = itrd_pkg::ST_TERM;
          end else begin
            idx_nxt = idx_r - 1'b1;
          end
        end
      end
      itrd_pkg::ST_TERM: begin
        if (emit_ok) begin
          out_valid_nxt = 1'b1;
          symbol_nxt    = itrd_pkg::TERM_CODE;
          last_nxt      = 1'b1;
          length_nxt    = ndig_r + {{(itrd_pkg::LENGTH_W-1){1'b0}}, neg_r} + 1'b1;
          state_nxt     = itrd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = itrd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= itrd_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r   <= work_nxt;
    rem_r    <= rem_nxt;
    radix_r  <= radix_nxt;
    neg_r    <= neg_nxt;
    step_r   <= step_nxt;
    ndig_r   <= ndig_nxt;
    idx_r    <= idx_nxt;
    symbol_r <= symbol_nxt;
    last_r   <= last_nxt;
    length_r <= length_nxt;
  end

  always_ff @(posedge clk) begin
    if (dig_we) begin
      dig_mem[ndig_r[itrd_pkg::DIG_IDX_W-1:0]] <= part[itrd_pkg::DIGIT_W-1:0];
    end
    // A digit written at this edge to the address being read is forwarded.
    if (dig_we && (idx_nxt == ndig_r[itrd_pkg::DIG_IDX_W-1:0])) begin
      dig_rd_r <= part[itrd_pkg::DIGIT_W-1:0];
    end else begin
      dig_rd_r <= dig_mem[idx_nxt];
    end
  end

  a_accept_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r == itrd_pkg::ST_DIV))
    else $error("transfer accepted without starting the division");

  a_rem_below_radix: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == itrd_pkg::ST_DIV) |-> (rem_r < radix_r))
    else $error("running remainder not below the base");

  a_last_is_term: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && last_r) |->
      (symbol_r == itrd_pkg::TERM_CODE && length_r >= itrd_pkg::LENGTH_W'(2)))
    else $error("final symbol is not a terminator with a sane length");

  a_digit_below_radix: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !last_r && symbol_r != itrd_pkg::SIGN_CODE) |->
      (symbol_r < {{(itrd_pkg::SYMBOL_W-itrd_pkg::RADIX_W){1'b0}}, radix_r}))
    else $error("emitted digit not below the base");

  a_length_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !last_r) |-> (length_r == '0))
    else $error("length set on a symbol that is not the last");

endmodule

@@ tb/sv/tb_integer_to_radix_digits_core.sv @@
`timescale 1ns / 100ps

module tb_integer_to_radix_digits_core;

  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 4000;
  localparam int DRAIN_CYCLES  = 200;
  localparam int RANDOM_ITEMS  = 310;
  localparam int CALM_ITEMS    = 80;
  localparam int HOLD_AT_ITEM  = 140;
  localparam int MAX_REPORTS   = 30;

  typedef struct packed {
    logic [itrd_pkg::SYMBOL_W-1:0] symbol;
    logic                          last;
    logic [itrd_pkg::LENGTH_W-1:0] length;
  } digit_sym_t;

  class digit_scoreboard;
    digit_sym_t pending_symbols[$];
    int errors;
    int conversions;
    int negatives;
    int clamped;
    int symbols_seen;

    function new();
      errors = 0;
      conversions = 0;
      negatives = 0;
      clamped = 0;
      symbols_seen = 0;
    endfunction

    task report_mismatch(string msg);
      if (errors < MAX_REPORTS) begin
        $display("[%0t] mismatch: %s", $realtime, msg);
      end
      errors++;
    endtask

    // Works out the symbol burst for one accepted conversion.
    function void note_conversion(logic [itrd_pkg::VALUE_W-1:0] value,
                                  logic [itrd_pkg::RADIX_W-1:0] radix);
      logic [itrd_pkg::VALUE_W-1:0] mag;
      logic [itrd_pkg::RADIX_W-1:0] base;
      logic [itrd_pkg::DIGIT_W-1:0] rev [itrd_pkg::MAX_DIGITS];
      int ndig;
      int count;
      conversions++;
      if (radix < itrd_pkg::RADIX_MIN || radix > itrd_pkg::RADIX_MAX) begin
        clamped++;
      end
      base = (radix < itrd_pkg::RADIX_MIN) ? itrd_pkg::RADIX_MIN :
             ((radix > itrd_pkg::RADIX_MAX) ? itrd_pkg::RADIX_MAX : radix);
      mag = value[itrd_pkg::VALUE_W-1] ? (~value + 1'b1) : value;
      ndig = 0;
      // The loop always runs once, so zero yields the single digit 0.
      do begin
        rev[ndig] = itrd_pkg::DIGIT_W'(mag % base);
        mag = mag / base;
        ndig++;
      end while (mag != 0);
      count = 0;
      if (value[itrd_pkg::VALUE_W-1]) begin
        negatives++;
        pending_symbols.push_back('{symbol: itrd_pkg::SIGN_CODE, last: 1'b0, length: '0});
        count++;
      end
      for (int j = ndig - 1; j >= 0; j--) begin
        pending_symbols.push_back('{symbol: itrd_pkg::SYMBOL_W'(rev[j]), last: 1'b0,
                                    length: '0});
        count++;
      end
      pending_symbols.push_back('{symbol: itrd_pkg::TERM_CODE, last: 1'b1,
                                  length: itrd_pkg::LENGTH_W'(count + 1)});
    endfunction

    task check_symbol(logic [itrd_pkg::SYMBOL_W-1:0] symbol, logic last,
                      logic [itrd_pkg::LENGTH_W-1:0] length);
      digit_sym_t want;
      symbols_seen++;
      if (pending_symbols.size() == 0) begin
        report_mismatch($sformatf("symbol %0d last %0b length %0d with nothing pending",
                                  symbol, last, length));
        return;
      end
      want = pending_symbols.pop_front();
      if (symbol !== want.symbol) begin
        report_mismatch($sformatf("symbol %0d, expected %0d", symbol, want.symbol));
      end
      if (last !== want.last) begin
        report_mismatch($sformatf("last %0b, expected %0b", last, want.last));
      end
      if (length !== want.length) begin
        report_mismatch($sformatf("length %0d, expected %0d", length, want.length));
      end
    endtask

    task conclude();
      if (pending_symbols.size() != 0) begin
        report_mismatch($sformatf("%0d symbols never arrived", pending_symbols.size()));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  bit   gaps_on;
  bit   hold_request;
  int   idle_cycles;
  digit_scoreboard sb;

  itrd_in_if  in_ch();
  itrd_out_if out_ch();

  integer_to_radix_digits_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Both channel monitors run in the active region of the rising edge, so they see
  // the values that were present when the transfer happened.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        sb.note_conversion(in_ch.value, in_ch.radix);
      end
      if (out_ch.valid && out_ch.ready) begin
        sb.check_symbol(out_ch.symbol, out_ch.last, out_ch.length);
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("No transfer for %0d cycles", STALL_LIMIT);
        $display("tb_integer_to_radix_digits_core NOT OK");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Result side: random back-pressure, plus one long hold-off that lets the block fill up.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        out_ch.ready <= !gaps_on || ($urandom_range(99) >= 31);
      end
    end
  end

  task drive_conversion(input logic [itrd_pkg::VALUE_W-1:0] value,
                        input logic [itrd_pkg::RADIX_W-1:0] radix);
    while (gaps_on && $urandom_range(99) < 31) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= value;
    in_ch.radix <= radix;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  function automatic logic [itrd_pkg::VALUE_W-1:0] random_value();
    logic [itrd_pkg::VALUE_W-1:0] v;
    case ($urandom_range(9))
      0, 1, 2, 3: v = $urandom;
      4, 5:       v = $urandom_range(0, 300);
      6:          v = -$urandom_range(1, 300);
      7: begin
        case ($urandom_range(4))
          0:       v = 32'h8000_0000;
          1:       v = 32'h7FFF_FFFF;
          2:       v = '0;
          3:       v = '1;
          default: v = 32'd1;
        endcase
      end
      default: begin
        v = $urandom >> $urandom_range(0, 31);
        if ($urandom_range(1)) begin
          v = -v;
        end
      end
    endcase
    return v;
  endfunction

  function automatic logic [itrd_pkg::RADIX_W-1:0] random_radix();
    if ($urandom_range(99) < 85) begin
      return itrd_pkg::RADIX_W'($urandom_range(itrd_pkg::RADIX_MIN, itrd_pkg::RADIX_MAX));
    end
    return itrd_pkg::RADIX_W'($urandom_range(0, 31));
  endfunction

  initial begin
    sb = new();
    gaps_on = 1'b1;
    hold_request = 1'b0;
    idle_cycles = 0;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.value <= '0;
    in_ch.radix <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero, the most negative and most positive values, and bases at and past the limits.
    drive_conversion(32'd0, 5'd10);
    drive_conversion(32'd0, 5'd2);
    drive_conversion(32'h8000_0000, 5'd2);
    drive_conversion(32'h8000_0000, 5'd16);
    drive_conversion(32'h8000_0000, 5'd10);
    drive_conversion(32'h7FFF_FFFF, 5'd2);
    drive_conversion(32'h7FFF_FFFF, 5'd16);
    drive_conversion(32'hFFFF_FFFF, 5'd16);
    drive_conversion(32'd1, 5'd2);
    drive_conversion(32'd15, 5'd16);
    drive_conversion(32'd16, 5'd16);
    drive_conversion(32'd35, 5'd10);
    drive_conversion(-32'sd35, 5'd10);
    drive_conversion(32'd26, 5'd3);
    drive_conversion(32'd48, 5'd7);
    drive_conversion(32'd5, 5'd0);
    drive_conversion(-32'sd5, 5'd1);
    drive_conversion(32'd255, 5'd17);
    drive_conversion(32'd255, 5'd31);
    drive_conversion(32'hFFFF_FFFF, 5'd31);
    drive_conversion(32'hDEAD_BEEF, 5'd15);
    drive_conversion(32'h1234_5678, 5'd9);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      gaps_on = (i >= CALM_ITEMS);
      if (i == HOLD_AT_ITEM) begin
        hold_request = 1'b1;
      end
      drive_conversion(random_value(), random_radix());
    end
    in_ch.valid <= 1'b0;

    while (sb.pending_symbols.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.conclude();

    $display("Converted %0d values (%0d negative, %0d with an out-of-range base), %0d symbols.",
             sb.conversions, sb.negatives, sb.clamped, sb.symbols_seen);
    $display("Random gaps on both channels and a %0d-cycle output stall were applied.",
             HOLD_CYCLES);
    if (sb.errors == 0) begin
      $display("tb_integer_to_radix_digits_core OK");
    end else begin
      $display("tb_integer_to_radix_digits_core NOT OK");
    end
    $finish;
  end

endmodule

@@ integer_to_radix_digits_core.f @@
rtl/itrd_pkg.sv
rtl/itrd_in_if.sv
rtl/itrd_out_if.sv
rtl/integer_to_radix_digits_core.sv
tb/sv/tb_integer_to_radix_digits_core.sv
